// ----- rtl/tli_pkg.sv -----
package tli_pkg;
    localparam int DEPTH = 256;
    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 9;

    localparam logic [CFG_IW-1:0] REG_LENGTH = 2'd0;
    localparam logic [CFG_IW-1:0] REG_EXT_BELOW = 2'd1;
    localparam logic [CFG_IW-1:0] REG_EXT_ABOVE = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    typedef struct packed {
        logic        func;
        logic [7:0]  entry_index;
        logic [31:0] x_value;
        logic [31:0] y_value;
    } t_in;

    typedef struct packed {
        logic [31:0] result;
        logic [1:0]  status;
    } t_out;

    typedef struct packed {
        logic        start;
        logic [31:0] xa;
        logic [31:0] xb;
        logic [31:0] ya;
        logic [31:0] yb;
        logic [31:0] q;
    } t_line_req;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
        logic        sat;
    } t_line_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_FIRST, S_CHK_FIRST, S_RD_LAST, S_CHK_LAST,
        S_SRCH, S_SRCH_RD, S_SRCH_W, S_RD_PAIR, S_PAIR_W, S_RD_PAIR2, S_LINE_W, S_OUT
    } t_state;

    typedef enum logic [2:0] {L_IDLE, L_MUL, L_DIV, L_SUM, L_DONE} t_lstate;
endpackage

// ----- rtl/tli_if.sv -----
interface tli_in_if (input logic i_clk);
    logic          valid;
    logic          ready;
    tli_pkg::t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tli_out_if (input logic i_clk);
    logic          valid;
    logic          ready;
    tli_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/tli_ram.sv -----
module tli_ram #(
    parameter int AWIDTH = 8,
    parameter int DWIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AWIDTH-1:0] i_waddr,
    input  logic [DWIDTH-1:0] i_wdata,
    input  logic [AWIDTH-1:0] i_raddr,
    output logic [DWIDTH-1:0] o_rdata
);
    logic [DWIDTH-1:0] r_mem [2**AWIDTH];
    logic [DWIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/tli_line.sv -----
module tli_line (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tli_pkg::t_line_req  i_req,
    output tli_pkg::t_line_rsp  o_rsp
);
    import tli_pkg::*;

    function automatic logic [32:0] sext(input logic [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic [32:0] mag(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    t_lstate      r_st, n_st;
    logic [32:0]  r_mdy, r_mdq, r_mdx;
    logic         r_neg, r_eq;
    logic signed [32:0] r_ya;
    logic [65:0]  r_rem;
    logic [65:0]  r_num;
    logic [6:0]   r_cnt;
    logic [65:0]  r_quo;
    logic [31:0]  r_val;
    logic         r_sat;

    logic signed [32:0] w_dy, w_dq, w_dx;
    logic [65:0]  w_trial;
    logic signed [67:0] w_sum;

    assign w_dy = $signed(sext(i_req.yb)) - $signed(sext(i_req.ya));
    assign w_dq = $signed(sext(i_req.q)) - $signed(sext(i_req.xa));
    assign w_dx = $signed(sext(i_req.xb)) - $signed(sext(i_req.xa));
    assign w_trial = {r_rem[64:0], r_num[65]};
    assign w_sum = {{35{r_ya[32]}}, r_ya}
                 + (r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo}));

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            L_IDLE: if (i_req.start) n_st = L_MUL;
            L_MUL:  n_st = r_eq ? L_DONE : L_DIV;
            L_DIV:  if (r_cnt == 7'd65) n_st = L_SUM;
            L_SUM:  n_st = L_DONE;
            L_DONE: n_st = L_IDLE;
            default: n_st = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= L_IDLE;
        end else begin
            r_st <= n_st;
        end
        unique case (r_st)
            L_IDLE: begin
                r_mdy <= mag(w_dy);
                r_mdq <= mag(w_dq);
                r_mdx <= mag(w_dx);
                r_neg <= w_dy[32] ^ w_dq[32] ^ w_dx[32];
                r_eq  <= (i_req.xa == i_req.xb);
                r_ya  <= $signed(sext(i_req.ya));
                r_val <= i_req.ya;
                r_sat <= 1'b0;
            end
            L_MUL: begin
                r_num <= 66'(r_mdy * r_mdq);
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= '0;
            end
            L_DIV: begin
                r_num <= {r_num[64:0], 1'b0};
                if (w_trial >= {33'd0, r_mdx}) begin
                    r_rem <= w_trial - {33'd0, r_mdx};
                    r_quo <= {r_quo[64:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[64:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
            end
            L_SUM: begin
                if (w_sum > 68'sh7FFFFFFF) begin
                    r_val <= 32'h7FFFFFFF;
                    r_sat <= 1'b1;
                end else if (w_sum < -68'sh80000000) begin
                    r_val <= 32'h80000000;
                    r_sat <= 1'b1;
                end else begin
                    r_val <= w_sum[31:0];
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.done = (r_st == L_DONE);
    assign o_rsp.value = r_val;
    assign o_rsp.sat = r_sat;
endmodule

// ----- rtl/table_linear_interpolator.sv -----
// channel | dir | payload                                   | handshake
// s_in    | in  | func, entry_index, x_value, y_value        | valid/ready
// m_out   | out | result, status                            | valid/ready
// cfg     | in  | i_cfg_we, i_cfg_index, i_cfg_data          | write only
// A write is taken in the idle state. A query reads and checks the end breakpoints,
// runs a binary search (9 steps at 256 entries), fetches the pair and runs the
// shift-subtract divider, which is skipped when the pair has equal x.
// Clamped queries finish right after the end checks; short-table queries skip them.
// Reset is synchronous and clears control only; the table is undefined.
// A result waits in the output register; the next item is taken once it leaves.
module table_linear_interpolator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tli_in_if.sink                     s_in,
    tli_out_if.source                  m_out,
    input  logic                       i_cfg_we,
    input  logic [tli_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [tli_pkg::CFG_DW-1:0] i_cfg_data
);
    import tli_pkg::*;

    t_state      r_st, n_st;
    logic [LW-1:0] r_len;
    logic        r_eb, r_ea;
    logic [31:0] r_q;
    logic [LW-1:0] r_lo, r_hi, r_n;
    logic [AW-1:0] r_addr;
    logic [31:0] r_xa, r_ya;
    logic        r_ovalid;
    t_out        r_out;
    logic        r_srch;

    logic [63:0] w_rd;
    logic [31:0] w_rx, w_ry;
    logic        w_we;
    logic        w_start;
    logic [LW-1:0] w_mid;
    t_line_req   w_req;
    t_line_rsp   w_rsp;

    assign w_we = s_in.valid && s_in.ready && (s_in.data.func == FUNC_WRITE);
    assign w_rx = w_rd[63:32];
    assign w_ry = w_rd[31:0];
    assign w_mid = LW'((r_lo + r_hi) >> 1);

    tli_ram #(.AWIDTH(AW), .DWIDTH(64)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(s_in.data.entry_index[AW-1:0]),
        .i_wdata({s_in.data.x_value, s_in.data.y_value}),
        .i_raddr(r_addr), .o_rdata(w_rd)
    );

    assign w_req.start = w_start;
    assign w_req.xa = r_xa;
    assign w_req.ya = r_ya;
    assign w_req.xb = w_rx;
    assign w_req.yb = w_ry;
    assign w_req.q = r_q;

    tli_line u_line (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign s_in.ready = (r_st == S_IDLE) && !r_ovalid;
    assign m_out.valid = r_ovalid;
    assign m_out.data = r_out;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (s_in.valid && s_in.ready && s_in.data.func == FUNC_QUERY)
                n_st = (r_len < LW'(2)) ? S_OUT : S_RD_FIRST;
            S_RD_FIRST: n_st = S_CHK_FIRST;
            S_CHK_FIRST: n_st = ($signed(r_q) < $signed(w_rx)) ?
                (r_eb ? S_RD_PAIR : S_OUT) : S_RD_LAST;
            S_RD_LAST: n_st = S_CHK_LAST;
            S_CHK_LAST: n_st = ($signed(r_q) > $signed(w_rx)) ?
                (r_ea ? S_RD_PAIR : S_OUT) : S_SRCH;
            S_SRCH: n_st = (r_lo < r_hi) ? S_SRCH_RD : S_RD_PAIR;
            S_SRCH_RD: n_st = S_SRCH_W;
            S_SRCH_W: n_st = S_SRCH;
            S_RD_PAIR: n_st = S_PAIR_W;
            S_PAIR_W: n_st = S_RD_PAIR2;
            S_RD_PAIR2: n_st = S_LINE_W;
            S_LINE_W: if (w_rsp.done) n_st = S_OUT;
            S_OUT: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    assign w_start = (r_st == S_LINE_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_len <= '0;
            r_eb <= 1'b0;
            r_ea <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_LENGTH: r_len <= (i_cfg_data > CFG_DW'(DEPTH)) ?
                        LW'(DEPTH) : LW'(i_cfg_data);
                    REG_EXT_BELOW: r_eb <= i_cfg_data[0];
                    REG_EXT_ABOVE: r_ea <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
            if (r_st == S_OUT) r_ovalid <= 1'b1;
        end
        unique case (r_st)
            S_IDLE: begin
                if (!r_ovalid) begin
                    r_q <= s_in.data.x_value;
                    r_n <= r_len;
                    r_addr <= '0;
                    r_out <= '{result: 32'd0, status: ST_SHORT};
                end
            end
            S_CHK_FIRST: begin
                r_out <= '{result: w_ry, status: ST_OK};
                r_srch <= 1'b0;
                r_lo <= '0;
                r_addr <= AW'(r_n - LW'(1));
            end
            S_CHK_LAST: begin
                r_out <= '{result: w_ry, status: ST_OK};
                r_lo <= ($signed(r_q) > $signed(w_rx)) ? r_n - LW'(2) : '0;
                r_hi <= r_n;
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    r_addr <= AW'(w_mid);
                end else begin
                    r_srch <= 1'b1;
                    if (r_lo >= r_n) r_lo <= r_n - LW'(1);
                end
            end
            S_SRCH_W: begin
                if ($signed(w_rx) < $signed(r_q)) r_lo <= w_mid + LW'(1);
                else r_hi <= w_mid;
            end
            S_RD_PAIR: begin
                r_addr <= (r_srch && r_lo != '0) ? AW'(r_lo - LW'(1)) : AW'(r_lo);
            end
            S_PAIR_W: begin
                r_addr <= (r_srch && r_lo != '0) ? AW'(r_lo) : AW'(r_lo + LW'(1));
            end
            S_RD_PAIR2: begin
                r_xa <= w_rx;
                r_ya <= w_ry;
            end
            S_LINE_W: begin
                if (w_rsp.done) begin
                    r_out <= '{result: w_rsp.value, status: w_rsp.sat ? ST_SAT : ST_OK};
                end
            end
            default: ;
        endcase
    end
endmodule

// ----- rtl/tli_checker.sv -----
module tli_props (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] out_status,
    input logic [31:0] out_result
);
    import tli_pkg::*;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_status))
        else $error("output word dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result raised on accept");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_status == ST_SHORT |-> out_result == 32'd0)
        else $error("short table result not zero");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_status != 2'd3)
        else $error("bad status");
endmodule

bind table_linear_interpolator tli_props u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready),
    .out_status(m_out.data.status), .out_result(m_out.data.result)
);
